/* sv/tnp_pkg.sv */
// Package for the telemetry nibble packer: widths, codes, result types and
// the character decoder. No dependencies.
package tnp_pkg;

    localparam int CNT_W          = 13;
    localparam int MAX_PACKED_LEN = 4096;
    localparam int DATA_W         = 32;
    localparam int PADDR_W        = 3;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] MAX_LEN       = CNT_W'(MAX_PACKED_LEN);
    localparam logic [CNT_W-1:0] MAX_OUT_RESET = CNT_W'(MAX_PACKED_LEN);

    localparam logic REG_MAX_OUT_BYTES = 1'b0;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    localparam logic [7:0] HDR_M = 8'hA1;
    localparam logic [7:0] HDR_G = 8'hA2;
    localparam logic [7:0] HDR_T = 8'hA3;
    localparam logic [3:0] PAD_NIBBLE = 4'hA;
    localparam logic [3:0] NIB_COLON  = 4'hB;
    localparam logic [3:0] NIB_ZERO   = 4'hC;
    localparam logic [3:0] NIB_DOT    = 4'hD;
    localparam logic [3:0] NIB_DASH   = 4'hE;
    localparam logic [3:0] NIB_COMMA  = 4'hF;

    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             is_last_result;
        logic [CNT_W-1:0] byte_count;
        logic             overflow;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic       is_sym;
        logic       is_hdr;
        logic [7:0] code;
    } t_sym;

    function automatic t_sym decode_char(input logic [7:0] ch);
        t_sym s;
        s = '{is_sym: 1'b1, is_hdr: 1'b0, code: 8'h00};
        case (ch)
            CH_M: begin
                s.is_hdr = 1'b1;
                s.code   = HDR_M;
            end
            CH_G: begin
                s.is_hdr = 1'b1;
                s.code   = HDR_G;
            end
            CH_T: begin
                s.is_hdr = 1'b1;
                s.code   = HDR_T;
            end
            CH_COLON: s.code = {4'h0, NIB_COLON};
            CH_ZERO:  s.code = {4'h0, NIB_ZERO};
            CH_DOT:   s.code = {4'h0, NIB_DOT};
            CH_DASH:  s.code = {4'h0, NIB_DASH};
            CH_COMMA: s.code = {4'h0, NIB_COMMA};
            default: begin
                if (ch >= CH_ONE && ch <= CH_NINE) begin
                    s.code = {4'h0, ch[3:0]};
                end else begin
                    s.is_sym = 1'b0;
                end
            end
        endcase
        return s;
    endfunction

endpackage

/* sv/tnp_in_if.sv */
// Input channel of the telemetry nibble packer: one character per item.
// Depends on nothing.
interface tnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_end;

    modport source(output valid, output in_char, output is_end, input ready);
    modport sink(input valid, input in_char, input is_end, output ready);
endinterface

/* sv/tnp_out_if.sv */
// Output channel of the telemetry nibble packer: one packed byte per item.
// Depends on tnp_pkg for the count width.
interface tnp_out_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                out_byte;
    logic                      byte_valid;
    logic                      is_last_result;
    logic [tnp_pkg::CNT_W-1:0] byte_count;
    logic                      overflow;

    modport source(output valid, output out_byte, output byte_valid,
                   output is_last_result, output byte_count, output overflow,
                   input ready);
    modport sink(input valid, input out_byte, input byte_valid,
                 input is_last_result, input byte_count, input overflow,
                 output ready);
endinterface

/* sv/tnp_cfg.sv */
// APB-style configuration register for the output byte limit.
// Depends on tnp_pkg.
module tnp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tnp_pkg::PADDR_W-1:0] paddr,
    input  logic [tnp_pkg::DATA_W-1:0]  pwdata,
    output logic [tnp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [tnp_pkg::CNT_W-1:0]   o_max_out_bytes
);
    import tnp_pkg::*;

    logic [CNT_W-1:0] r_max_out_bytes;
    logic             reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out_bytes <= MAX_OUT_RESET;
        end else if (wr_en && reg_idx == REG_MAX_OUT_BYTES) begin
            r_max_out_bytes <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_MAX_OUT_BYTES) ?
                    {{(DATA_W-CNT_W){1'b0}}, r_max_out_bytes} : '0;
    assign o_max_out_bytes = r_max_out_bytes;

endmodule

/* sv/tnp_pack.sv */
// Input register and packing logic: decodes one character, updates the
// nibble and count state, and pushes up to two results. Depends on tnp_pkg.
module tnp_pack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_in_char,
    input  logic                      i_is_end,
    input  logic [tnp_pkg::CNT_W-1:0] i_max_out_bytes,
    input  logic                      i_space,
    output tnp_pkg::t_push            o_push
);
    import tnp_pkg::*;

    logic             r_valid;
    logic [7:0]       r_char;
    logic             r_end;
    logic             r_pend;
    logic [3:0]       r_nib;
    logic [CNT_W-1:0] r_be;
    logic             r_dropped;

    logic             go;
    t_sym             sym;
    logic [1:0]       ncand;
    logic [7:0]       c0;
    logic [7:0]       c1;
    logic             n_pend;
    logic [3:0]       n_nib;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] be1;
    logic [CNT_W-1:0] be2;
    logic             room0;
    logic             room1;
    logic             e0;
    logic             e1;
    logic             n_dropped;
    logic [CNT_W-1:0] n_be;
    t_push            push;

    assign go      = r_valid && i_space;
    assign o_ready = !r_valid || i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_in_char;
            r_end  <= i_is_end;
        end
    end

    always_comb begin
        sym    = decode_char(r_char);
        ncand  = PUSH_NONE;
        c0     = 8'h00;
        c1     = 8'h00;
        n_pend = r_pend;
        n_nib  = r_nib;
        if (sym.is_sym) begin
            if (sym.is_hdr) begin
                if (r_pend) begin
                    c0    = {r_nib, PAD_NIBBLE};
                    c1    = sym.code;
                    ncand = PUSH_TWO;
                end else begin
                    c0    = sym.code;
                    ncand = PUSH_ONE;
                end
                n_pend = 1'b0;
            end else if (!r_pend) begin
                n_nib  = sym.code[3:0];
                n_pend = 1'b1;
            end else begin
                c0     = {r_nib, sym.code[3:0]};
                ncand  = PUSH_ONE;
                n_pend = 1'b0;
            end
        end
        if (r_end && n_pend) begin
            c0    = {n_nib, PAD_NIBBLE};
            ncand = PUSH_ONE;
        end
    end

    always_comb begin
        lim       = (i_max_out_bytes > MAX_LEN) ? MAX_LEN : i_max_out_bytes;
        be1       = r_be + CNT_W'(1);
        be2       = r_be + CNT_W'(2);
        room0     = r_be < lim;
        room1     = be1 < lim;
        e0        = (ncand != PUSH_NONE) && room0;
        e1        = (ncand == PUSH_TWO) && room1;
        n_dropped = r_dropped || ((ncand != PUSH_NONE) && !room0)
                    || ((ncand == PUSH_TWO) && !room1);
        n_be      = e1 ? be2 : (e0 ? be1 : r_be);

        push.res0 = '{out_byte: c0, byte_valid: 1'b1, is_last_result: 1'b0,
                      byte_count: be1, overflow: r_dropped};
        push.res1 = '{out_byte: c1, byte_valid: 1'b1, is_last_result: 1'b0,
                      byte_count: be2, overflow: r_dropped};
        push.num  = e1 ? PUSH_TWO : (e0 ? PUSH_ONE : PUSH_NONE);

        if (r_end) begin
            if (!e0) begin
                push.res0 = '{out_byte: 8'h00, byte_valid: 1'b0, is_last_result: 1'b1,
                              byte_count: r_be, overflow: n_dropped};
                push.num  = PUSH_ONE;
            end else if (e1) begin
                push.res1.is_last_result = 1'b1;
                push.res1.overflow       = n_dropped;
            end else begin
                push.res0.is_last_result = 1'b1;
                push.res0.overflow       = n_dropped;
            end
        end

        o_push = push;
        if (!go) begin
            o_push.num = PUSH_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_be      <= '0;
            r_dropped <= 1'b0;
        end else if (go) begin
            if (r_end) begin
                r_pend    <= 1'b0;
                r_be      <= '0;
                r_dropped <= 1'b0;
            end else begin
                r_pend    <= n_pend;
                r_be      <= n_be;
                r_dropped <= n_dropped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_nib <= n_nib;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_end) |=> (r_be == '0 && !r_pend && !r_dropped))
        else $error("string state not cleared after end item");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_end) |-> (o_push.num != PUSH_NONE))
        else $error("end item produced no result");

    a_two_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num == PUSH_TWO) |-> (o_push.res0.byte_valid && o_push.res1.byte_valid))
        else $error("double push carries an end marker");

endmodule

/* sv/tnp_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle
// while the reader is ready. Depends on tnp_pkg.
module tnp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tnp_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output tnp_pkg::t_result o_res
);
    import tnp_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_count;
    logic               pop;

    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_space = r_count <= FIFO_CW'(FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push.num);
            r_rd    <= r_rd + FIFO_AW'(pop);
            r_count <= r_count + FIFO_CW'(i_push.num) - FIFO_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != PUSH_NONE) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == PUSH_TWO) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.res1;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != PUSH_NONE) |-> o_space)
        else $error("push into queue without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

/* sv/telemetry_nibble_packer_top.sv */
// Telemetry nibble packer. An accepted item is held in the input register; its
// results are written to the result queue together and offered one after another.
// One item per cycle while the queue has room for two results; an item that yields
// two results (a header after a pending nibble) takes two entries in the queue.
// Reset: synchronous active-low i_rst_n clears all string state and the queue,
// and sets the byte limit to 4096. Depends on tnp_pkg and both channel interfaces.
module telemetry_nibble_packer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tnp_in_if.sink                      i_in,
    tnp_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tnp_pkg::PADDR_W-1:0] paddr,
    input  logic [tnp_pkg::DATA_W-1:0]  pwdata,
    output logic [tnp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import tnp_pkg::*;

    logic [CNT_W-1:0] max_out_bytes;
    logic             space;
    t_push            push;
    t_result          res;

    tnp_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_max_out_bytes (max_out_bytes)
    );

    tnp_pack u_pack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_in_char       (i_in.in_char),
        .i_is_end        (i_in.is_end),
        .i_max_out_bytes (max_out_bytes),
        .i_space         (space),
        .o_push          (push)
    );

    tnp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.out_byte       = res.out_byte;
    assign o_out.byte_valid     = res.byte_valid;
    assign o_out.is_last_result = res.is_last_result;
    assign o_out.byte_count     = res.byte_count;
    assign o_out.overflow       = res.overflow;

endmodule
